// ===== hdl/srn_pkg.sv =====
// Package: widths and payload types for the signed nearest-remainder unit.
package srn_pkg;

    // Width of the request and response fields on the ports
    localparam int FIELD_W = 64;
    // Operand width used for the arithmetic (2 to 64); upper input bits ignored
    localparam int DATA_W  = 64;
    // Register stages: input, one per remainder bit, rounding, output
    localparam int LATENCY = DATA_W + 3;

    typedef logic signed [FIELD_W-1:0] t_field;
    typedef logic        [DATA_W-1:0]  t_mag;
    typedef logic        [DATA_W:0]    t_mag_ext;

endpackage

// ===== hdl/srn_req_if.sv =====
// Interface: request channel carrying dividend and divisor.
interface srn_req_if;
    logic                  valid;
    logic                  ready;
    srn_pkg::t_field       dividend;
    srn_pkg::t_field       divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// Interface: response channel carrying remainder and divide-by-zero flag.
interface srn_rsp_if;
    logic                  valid;
    logic                  ready;
    srn_pkg::t_field       remainder;
    logic                  divide_by_zero;

    modport source (output valid, output remainder, output divide_by_zero, input ready);
    modport sink   (input valid, input remainder, input divide_by_zero, output ready);
endinterface

// ===== hdl/signed_remainder_nearest_unit.sv =====
// Top level: pipelined signed remainder with quotient rounded to nearest.
//
//  channel  | dir | payload                          | handshake
//  i_req    | in  | dividend, divisor (64b signed)   | valid/ready
//  o_rsp    | out | remainder (64b), divide_by_zero  | valid/ready
//
// One request enters per cycle while the pipeline advances; its response passes
// through one input stage, one restoring subtract stage per remainder bit,
// one rounding stage and the output register.
// Reset clears the valid bit of every stage; payload registers are not reset.
// The whole pipeline advances whenever the output register is empty or being
// taken; otherwise every stage holds, so nothing is dropped or repeated.
module signed_remainder_nearest_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    srn_req_if.sink        i_req,
    srn_rsp_if.source      o_rsp
);

    localparam int W = srn_pkg::DATA_W;

    // Pipeline advance
    logic w_en;
    assign w_en        = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = w_en;

    // Division stages 0..W: stage 0 is the input stage
    logic              r_vld [0:W];
    srn_pkg::t_mag     r_num [0:W];   // dividend magnitude, shifted left each stage
    srn_pkg::t_mag     r_rm  [0:W];   // partial remainder
    srn_pkg::t_mag     r_bm  [0:W];   // divisor magnitude
    logic              r_neg [0:W];   // sign of result before rounding
    logic              r_dz  [0:W];   // divisor was zero

    srn_pkg::t_mag     n_rm  [1:W];

    // Input stage: operand magnitudes
    srn_pkg::t_mag w_a;
    srn_pkg::t_mag w_b;
    srn_pkg::t_mag w_am;
    srn_pkg::t_mag w_bm;
    assign w_a  = i_req.dividend[W-1:0];
    assign w_b  = i_req.divisor[W-1:0];
    assign w_am = w_a[W-1] ? srn_pkg::t_mag'(-w_a) : w_a;
    assign w_bm = w_b[W-1] ? srn_pkg::t_mag'(-w_b) : w_b;

    // Restoring step: bring in one dividend bit, subtract divisor if it fits
    always_comb begin
        for (int k = 1; k <= W; k++) begin
            srn_pkg::t_mag_ext trial;
            srn_pkg::t_mag_ext diff;
            trial = {r_rm[k-1], r_num[k-1][W-1]};
            diff  = trial - {1'b0, r_bm[k-1]};
            if (trial >= {1'b0, r_bm[k-1]}) begin
                n_rm[k] = diff[W-1:0];
            end else begin
                n_rm[k] = trial[W-1:0];
            end
        end
    end

    // Valid bits of the division stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_req.valid;
            for (int k = 1; k <= W; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Payload of the division stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num[0] <= w_am;
            r_rm[0]  <= '0;
            r_bm[0]  <= w_bm;
            r_neg[0] <= w_a[W-1];
            r_dz[0]  <= (w_b == '0);
            for (int k = 1; k <= W; k++) begin
                r_num[k] <= {r_num[k-1][W-2:0], 1'b0};
                r_rm[k]  <= n_rm[k];
                r_bm[k]  <= r_bm[k-1];
                r_neg[k] <= r_neg[k-1];
                r_dz[k]  <= r_dz[k-1];
            end
        end
    end

    // Rounding stage: move by one divisor when twice the remainder reaches it
    logic              r_rnd_vld;
    srn_pkg::t_mag     r_rnd_mag;
    srn_pkg::t_mag     r_rnd_bm;
    logic              r_rnd_neg;
    logic              r_rnd_dz;

    logic              w_round;
    srn_pkg::t_mag     w_alt;
    assign w_round = {r_rm[W], 1'b0} >= {1'b0, r_bm[W]};
    assign w_alt   = r_bm[W] - r_rm[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_vld <= 1'b0;
        end else if (w_en) begin
            r_rnd_vld <= r_vld[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rnd_mag <= w_round ? w_alt : r_rm[W];
            r_rnd_neg <= w_round ? !r_neg[W] : r_neg[W];
            r_rnd_bm  <= r_bm[W];
            r_rnd_dz  <= r_dz[W];
        end
    end

    // Output register: apply sign, sign-extend, force zero on divide error
    logic              r_out_vld;
    srn_pkg::t_field   r_out_rem;
    logic              r_out_dz;
    srn_pkg::t_mag     w_signed;
    assign w_signed = r_rnd_neg ? srn_pkg::t_mag'(-r_rnd_mag) : r_rnd_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_rnd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_rem <= r_rnd_dz ? '0 : srn_pkg::t_field'(signed'(w_signed));
            r_out_dz  <= r_rnd_dz;
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.remainder      = r_out_rem;
    assign o_rsp.divide_by_zero = r_out_dz;

`ifndef SYNTHESIS
    // A flagged divide error always carries a zero remainder
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.divide_by_zero |-> o_rsp.remainder == '0)
        else $error("divide error with non-zero remainder");

    // Rounded magnitude never exceeds half the divisor
    a_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd_vld && !r_rnd_dz |-> {r_rnd_mag, 1'b0} <= {1'b0, r_rnd_bm})
        else $error("rounded remainder above half the divisor");

    // While the output is held, the rounding stage keeps its request
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_rnd_vld) && $stable(r_rnd_mag))
        else $error("pipeline moved during a stall");
`endif

endmodule
